@@ hw/rtl/aavg7s_pkg.sv @@
// ----------------------------------------------------------------------------
// aavg7s_pkg
// Shared widths, reset values and the seven-segment code table.
// ----------------------------------------------------------------------------
`default_nettype none

package aavg7s_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 12;
  localparam int ADC_BITS            = 12;
  localparam int LENGTH_BITS         = 16;
  localparam int LIMIT_BITS          = LENGTH_BITS + 1;
  localparam int AVG_OUT_BITS        = 12;
  localparam int SEG_WORD_BITS       = 31;
  localparam int DIGITS              = 4;
  localparam int BCD_BITS            = 4 * DIGITS;

  localparam logic [LENGTH_BITS-1:0] AVERAGE_LENGTH_RESET = 16'd1000;

  typedef logic [7:0] seg_byte_t;

  // active high, segment a in bit 0
  function automatic seg_byte_t seg_code(input logic [3:0] digit);
    seg_byte_t code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/aavg7s_sample_if.sv @@
// ----------------------------------------------------------------------------
// aavg7s_sample_if
// Sample channel: one converter reading per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface aavg7s_sample_if;
  logic                              valid;
  logic                              ready;
  logic [aavg7s_pkg::ADC_BITS-1:0]   adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/aavg7s_result_if.sv @@
// ----------------------------------------------------------------------------
// aavg7s_result_if
// Result channel: packed segment word and the average.
// ----------------------------------------------------------------------------
`default_nettype none

interface aavg7s_result_if;
  logic                                   valid;
  logic                                   ready;
  logic [aavg7s_pkg::SEG_WORD_BITS-1:0]   segment_word;
  logic [aavg7s_pkg::AVG_OUT_BITS-1:0]    average_value;

  modport source (output valid, output segment_word, output average_value, input ready);
  modport sink   (input valid, input segment_word, input average_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/aavg7s_cfg_if.sv @@
// ----------------------------------------------------------------------------
// aavg7s_cfg_if
// Configuration write channel for the averaging length register.
// ----------------------------------------------------------------------------
`default_nettype none

interface aavg7s_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [aavg7s_pkg::LENGTH_BITS-1:0]   average_length;

  modport source (output valid, output average_length, input ready);
  modport sink   (input valid, input average_length, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/aavg7s_divider.sv @@
// ----------------------------------------------------------------------------
// aavg7s_divider
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aavg7s_divider #(
  parameter int DIVIDEND_BITS = aavg7s_pkg::SAMPLE_BITS_DEFAULT + aavg7s_pkg::LENGTH_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [DIVIDEND_BITS-1:0]              dividend,
  input  wire logic [aavg7s_pkg::LIMIT_BITS-1:0]     divisor,
  output logic                                       done,
  output logic [DIVIDEND_BITS-1:0]                   quotient
);

  localparam int LB    = aavg7s_pkg::LIMIT_BITS;
  localparam int CNT_W = $clog2(DIVIDEND_BITS);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [LB-1:0]             rem;
  logic [LB-1:0]             dvs;
  logic [LB:0]               shifted;
  logic [LB:0]               trial;

  always_comb begin
    shifted = {rem, quotient[DIVIDEND_BITS-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[LB]) begin
        rem      <= trial[LB-1:0];
        quotient <= {quotient[DIVIDEND_BITS-2:0], 1'b1};
      end else begin
        rem      <= shifted[LB-1:0];
        quotient <= {quotient[DIVIDEND_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/aavg7s_bcd.sv @@
// ----------------------------------------------------------------------------
// aavg7s_bcd
// Serial binary to four-digit BCD converter (shift and add-3).
// ----------------------------------------------------------------------------
`default_nettype none

module aavg7s_bcd #(
  parameter int VALUE_BITS = aavg7s_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [VALUE_BITS-1:0]                value,
  output logic                                      done,
  output logic [aavg7s_pkg::BCD_BITS-1:0]           bcd
);

  localparam int BB    = aavg7s_pkg::BCD_BITS;
  localparam int CNT_W = $clog2(VALUE_BITS);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] bits;
  logic [BB-1:0]         adj;

  always_comb begin
    adj = bcd;
    for (int k = 0; k < aavg7s_pkg::DIGITS; k++) begin
      if (bcd[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bcd  <= '0;
      bits <= value;
    end else if (busy) begin
      bcd  <= {adj[BB-2:0], bits[VALUE_BITS-1]};
      bits <= bits << 1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/adc_average_to_seven_segment_top.sv @@
// ----------------------------------------------------------------------------
// adc_average_to_seven_segment_top
// Running sum of converter samples; every average_length samples (65536 if 0) the
// mean is formed and shown as four seven-segment bytes with leading zeros blanked.
// ----------------------------------------------------------------------------
//  channel  dir  payload                        word accepted when
//  cfg      in   average_length[15:0]           cfg.valid & cfg.ready
//  sample   in   adc_sample[11:0]               sample.valid & sample.ready
//  result   out  segment_word[30:0],            result.valid & result.ready
//                average_value[11:0]
//
//  A sample that does not close an average is taken in the idle state.
//  A closing sample runs the divider (S_DIV), then the BCD converter (S_BCD), then
//  waits in S_OUT to load the result register; sample.ready is low meanwhile.
//  The result register holds a word until taken; a new average waits for it.
//  Synchronous reset: length 1000, sum and count cleared, no result pending.
//  cfg.ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_average_to_seven_segment_top #(
  parameter int SAMPLE_BITS = aavg7s_pkg::SAMPLE_BITS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  aavg7s_cfg_if.sink         cfg,
  aavg7s_sample_if.sink      sample,
  aavg7s_result_if.source    result
);

  localparam int LEN_B = aavg7s_pkg::LENGTH_BITS;
  localparam int LIM_B = aavg7s_pkg::LIMIT_BITS;
  localparam int SUM_B = SAMPLE_BITS + LEN_B;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_BCD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [LEN_B-1:0]        average_length;
  logic [SUM_B-1:0]        sample_sum;
  logic [LEN_B-1:0]        sample_count;
  logic [SAMPLE_BITS-1:0]  avg;

  logic [SUM_B-1:0]        sum_next;
  logic [LIM_B-1:0]        count_inc;
  logic [LIM_B-1:0]        limit;
  logic                    accept;
  logic                    closing;
  logic                    div_done;
  logic [SUM_B-1:0]        quotient;
  logic [SAMPLE_BITS-1:0]  avg_sat;
  logic                    bcd_done;
  logic [aavg7s_pkg::BCD_BITS-1:0] bcd;
  logic                    load;
  logic [31:0]             word;
  logic                    show3;
  logic                    show2;
  logic                    show1;

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == S_IDLE);
  assign accept       = sample.valid && sample.ready;

  always_comb begin
    sum_next  = sample_sum + SUM_B'(SAMPLE_BITS'(sample.adc_sample));
    count_inc = {1'b0, sample_count} + LIM_B'(1);
    limit     = (average_length == '0) ? {1'b1, {LEN_B{1'b0}}} : {1'b0, average_length};
    closing   = (count_inc >= limit);
    avg_sat   = (quotient > SUM_B'({SAMPLE_BITS{1'b1}})) ? {SAMPLE_BITS{1'b1}}
                                                         : quotient[SAMPLE_BITS-1:0];
    load      = (state == S_OUT) && (!result.valid || result.ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && closing) state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_BCD;
      S_BCD:  if (bcd_done) state_next = S_OUT;
      S_OUT:  if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  aavg7s_divider #(.DIVIDEND_BITS(SUM_B)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && closing),
    .dividend (sum_next),
    .divisor  (limit),
    .done     (div_done),
    .quotient (quotient)
  );

  aavg7s_bcd #(.VALUE_BITS(SAMPLE_BITS)) u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start ((state == S_DIV) && div_done),
    .value (avg_sat),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  always_comb begin
    show3 = (bcd[15:12] != 4'd0);
    show2 = show3 || (bcd[11:8] != 4'd0);
    show1 = show2 || (bcd[7:4] != 4'd0);
    word  = {show3 ? aavg7s_pkg::seg_code(bcd[15:12]) : 8'h00,
             show2 ? aavg7s_pkg::seg_code(bcd[11:8])  : 8'h00,
             show1 ? aavg7s_pkg::seg_code(bcd[7:4])   : 8'h00,
             aavg7s_pkg::seg_code(bcd[3:0])};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      average_length <= aavg7s_pkg::AVERAGE_LENGTH_RESET;
      sample_sum     <= '0;
      sample_count   <= '0;
      result.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        average_length <= cfg.average_length;
      end
      if (accept) begin
        if (closing) begin
          sample_sum   <= '0;
          sample_count <= '0;
        end else begin
          sample_sum   <= sum_next;
          sample_count <= count_inc[LEN_B-1:0];
        end
      end
      if (load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DIV) && div_done) begin
      avg <= avg_sat;
    end
    if (load) begin
      result.segment_word  <= word[aavg7s_pkg::SEG_WORD_BITS-1:0];
      result.average_value <= aavg7s_pkg::AVG_OUT_BITS'(avg);
    end
  end

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for adc_average_to_seven_segment_top. A short table of
// directed words covers the reset length, the digit patterns, truncation,
// saturation after the length is lowered, and the widest lengths. Random
// phases follow: each phase sets a length and then streams samples, with
// random gaps on both channels. Every result is checked against a local
// model of the running sum, the divide and the segment encode.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_ITEMS  = 125;
  localparam int PLAN_ROWS     = 26;

  typedef struct packed {
    logic [aavg7s_pkg::SEG_WORD_BITS-1:0] seg;
    logic [aavg7s_pkg::AVG_OUT_BITS-1:0]  avg;
  } reading_t;

  typedef struct packed {
    logic                                 is_cfg;
    logic [aavg7s_pkg::LENGTH_BITS-1:0]   value;
    logic [aavg7s_pkg::LIMIT_BITS-1:0]    reps;
    logic                                 has_exp;
    logic [aavg7s_pkg::SEG_WORD_BITS-1:0] seg;
    logic [aavg7s_pkg::AVG_OUT_BITS-1:0]  avg;
  } plan_row_t;

  logic clk;
  logic rst;

  aavg7s_cfg_if    cfg_ch ();
  aavg7s_sample_if smp_ch ();
  aavg7s_result_if res_ch ();

  adc_average_to_seven_segment_top dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (smp_ch),
    .result (res_ch)
  );

  // model state
  logic [aavg7s_pkg::LENGTH_BITS-1:0]  avg_length;
  logic [aavg7s_pkg::ADC_BITS+15:0]    sum_acc;
  logic [aavg7s_pkg::LENGTH_BITS-1:0]  count_acc;
  reading_t                            readings_due [$];
  reading_t                            last_seen;

  int  mismatches   = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  cfg_writes   = 0;
  int  idle_cycles  = 0;
  bit  hold_req     = 0;
  bit  sink_quiet   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] glyph_of(input int unsigned d);
    case (d)
      0:       return 8'h3F;
      1:       return 8'h06;
      2:       return 8'h5B;
      3:       return 8'h4F;
      4:       return 8'h66;
      5:       return 8'h6D;
      6:       return 8'h7D;
      7:       return 8'h07;
      8:       return 8'h7F;
      default: return 8'h6F;
    endcase
  endfunction

  function automatic logic [aavg7s_pkg::SEG_WORD_BITS-1:0] pack_display(
      input int unsigned avg);
    logic [31:0] w;
    w[31:24] = (avg < 1000) ? 8'h00 : glyph_of((avg / 1000) % 10);
    w[23:16] = (avg < 100)  ? 8'h00 : glyph_of((avg / 100) % 10);
    w[15:8]  = (avg < 10)   ? 8'h00 : glyph_of((avg / 10) % 10);
    w[7:0]   = glyph_of(avg % 10);
    return w[aavg7s_pkg::SEG_WORD_BITS-1:0];
  endfunction

  function automatic void predict_reading(input logic [aavg7s_pkg::ADC_BITS-1:0] v);
    logic [aavg7s_pkg::LIMIT_BITS-1:0] limit;
    logic [aavg7s_pkg::LIMIT_BITS-1:0] nxt;
    logic [aavg7s_pkg::ADC_BITS+15:0]  q;
    reading_t                          r;
    limit   = (avg_length == '0) ? 17'd65536 : {1'b0, avg_length};
    sum_acc = sum_acc + v;
    nxt     = {1'b0, count_acc} + 17'd1;
    if (nxt < limit) begin
      count_acc = nxt[aavg7s_pkg::LENGTH_BITS-1:0];
    end else begin
      q = sum_acc / limit;
      if (q > 4095) q = {16'h0000, 12'hFFF};
      r.seg = pack_display(q);
      r.avg = q[aavg7s_pkg::AVG_OUT_BITS-1:0];
      readings_due.push_back(r);
      sum_acc   = '0;
      count_acc = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t MISMATCH %s: got %h want %h", $realtime, what, got, want);
  endtask

  task automatic check_reading(input string tag, input reading_t got, input reading_t want);
    if (got.seg !== want.seg) report_mismatch({tag, " segment_word"}, got.seg, want.seg);
    if (got.avg !== want.avg) report_mismatch({tag, " average_value"}, got.avg, want.avg);
  endtask

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      avg_length  = aavg7s_pkg::AVERAGE_LENGTH_RESET;
      sum_acc     = '0;
      count_acc   = '0;
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (res_ch.valid && res_ch.ready) begin
        idle_cycles = 0;
        results_seen++;
        last_seen = {res_ch.segment_word, res_ch.average_value};
        if (readings_due.size() == 0)
          report_mismatch("unexpected result", last_seen.seg, '0);
        else
          check_reading("result", last_seen, readings_due.pop_front());
      end
      if (smp_ch.valid && smp_ch.ready) begin
        idle_cycles = 0;
        predict_reading(smp_ch.adc_sample);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        idle_cycles = 0;
        avg_length = cfg_ch.average_length;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result sink with random stalls and one long hold
  initial begin : sink
    int w;
    res_ch.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        w = HOLD_CYCLES;
        hold_req = 0;
      end else if (sink_quiet || $urandom_range(0, 3) == 0) begin
        w = 0;
      end else begin
        w = $urandom_range(0, 16);
      end
      if (w > 0) begin
        res_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  task automatic send_sample(input logic [aavg7s_pkg::ADC_BITS-1:0] v, input int gap);
    if (gap > 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_ch.valid      <= 1'b1;
    smp_ch.adc_sample <= v;
    do @(posedge clk); while (!(smp_ch.valid && smp_ch.ready));
    samples_sent++;
  endtask

  task automatic settle();
    smp_ch.valid <= 1'b0;
    do @(posedge clk); while (readings_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [aavg7s_pkg::LENGTH_BITS-1:0] v);
    settle();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.average_length <= v;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [aavg7s_pkg::ADC_BITS-1:0] draw_sample(input int mode);
    if ($urandom_range(0, 7) == 0) return 12'($urandom_range(0, 4095));
    case (mode)
      0:       return 12'($urandom_range(0, 4095));
      1:       return 12'hFFF;
      2:       return 12'h000;
      3:       return 12'($urandom_range(0, 15));
      default: return 12'($urandom_range(4000, 4095));
    endcase
  endfunction

  initial begin : stim
    plan_row_t plan [PLAN_ROWS];
    int        i;
    int        k;
    int        n;
    int        phase;
    int        mode;
    int        pick;
    int        items;
    bit        burst;
    logic [aavg7s_pkg::LENGTH_BITS-1:0] len;

    plan = '{
      // cfg   value       reps       exp   segment_word    average
      '{1'b0, 16'd4095,  17'd1000,  1'b1, 31'h663F6F6D, 12'd4095},
      '{1'b1, 16'd1,     17'd0,     1'b0, 31'h0,        12'd0},
      '{1'b0, 16'd0,     17'd1,     1'b1, 31'h0000003F, 12'd0},
      '{1'b0, 16'd4095,  17'd1,     1'b1, 31'h663F6F6D, 12'd4095},
      '{1'b0, 16'd7,     17'd1,     1'b1, 31'h00000007, 12'd7},
      '{1'b0, 16'd42,    17'd1,     1'b1, 31'h0000665B, 12'd42},
      '{1'b0, 16'd305,   17'd1,     1'b1, 31'h004F3F6D, 12'd305},
      '{1'b0, 16'd1000,  17'd1,     1'b1, 31'h063F3F3F, 12'd1000},
      '{1'b0, 16'd2048,  17'd1,     1'b1, 31'h5B3F667F, 12'd2048},
      '{1'b0, 16'h0555,  17'd1,     1'b1, 31'h064F7D6D, 12'd1365},
      '{1'b0, 16'h0AAA,  17'd1,     1'b1, 31'h5B074F3F, 12'd2730},
      '{1'b0, 16'd10,    17'd1,     1'b1, 31'h0000063F, 12'd10},
      '{1'b0, 16'd99,    17'd1,     1'b1, 31'h00006F6F, 12'd99},
      '{1'b1, 16'd2,     17'd0,     1'b0, 31'h0,        12'd0},
      '{1'b0, 16'd4,     17'd1,     1'b0, 31'h0,        12'd0},
      // 11 / 2 truncates to 5
      '{1'b0, 16'd7,     17'd1,     1'b1, 31'h0000006D, 12'd5},
      '{1'b1, 16'd8,     17'd0,     1'b0, 31'h0,        12'd0},
      '{1'b0, 16'd4095,  17'd5,     1'b0, 31'h0,        12'd0},
      // length dropped under the count: six samples over two, saturates
      '{1'b1, 16'd2,     17'd0,     1'b0, 31'h0,        12'd0},
      '{1'b0, 16'd4095,  17'd1,     1'b1, 31'h663F6F6D, 12'd4095},
      // widest and zero lengths keep summing until the length is lowered
      '{1'b1, 16'd65535, 17'd0,     1'b0, 31'h0,        12'd0},
      '{1'b0, 16'd3,     17'd3,     1'b0, 31'h0,        12'd0},
      '{1'b1, 16'd0,     17'd0,     1'b0, 31'h0,        12'd0},
      '{1'b0, 16'd3,     17'd3,     1'b0, 31'h0,        12'd0},
      '{1'b1, 16'd4,     17'd0,     1'b0, 31'h0,        12'd0},
      // seven samples of 3 over four
      '{1'b0, 16'd3,     17'd1,     1'b1, 31'h0000006D, 12'd5}
    };

    rst                   <= 1'b1;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.average_length <= '0;
    smp_ch.valid          <= 1'b0;
    smp_ch.adc_sample     <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].is_cfg) begin
        write_length(plan[i].value);
      end else begin
        for (k = 0; k < plan[i].reps; k++)
          send_sample(plan[i].value[aavg7s_pkg::ADC_BITS-1:0],
                      (plan[i].reps > 8) ? 0 : $urandom_range(0, 16));
        if (plan[i].has_exp) begin
          settle();
          check_reading("table", last_seen, {plan[i].seg, plan[i].avg});
        end
      end
    end

    items = 0;
    phase = 0;
    while (items < RANDOM_ITEMS) begin
      phase++;
      pick = $urandom_range(0, 9);
      if (pick < 6)      len = 16'($urandom_range(1, 8));
      else if (pick < 8) len = 16'($urandom_range(9, 40));
      else if (pick < 9) len = 16'($urandom_range(100, 300));
      else               len = 1;
      mode  = $urandom_range(0, 4);
      burst = ($urandom_range(0, 3) == 0);
      n     = $urandom_range(1, 40);
      sink_quiet = ($urandom_range(0, 5) == 0);
      if (phase == 3) begin
        // fill the block behind a stalled sink
        len   = 1;
        burst = 1;
        n     = 30;
        sink_quiet = 0;
      end
      write_length(len);
      if (phase == 3) hold_req = 1;
      for (k = 0; k < n; k++)
        send_sample(draw_sample(mode), burst ? 0 : $urandom_range(0, 16));
      items += n;
    end

    settle();
    if (readings_due.size() != 0)
      report_mismatch("results never arrived", readings_due.size(), 0);

    $display("covered %0d samples, %0d results, %0d length writes over %0d random phases",
             samples_sent, results_seen, cfg_writes, phase);
    $display("lengths 0, 1 and 65535, truncation, saturation, blanking, long sink hold");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ adc_average_to_seven_segment_top.f @@
hw/rtl/aavg7s_pkg.sv
hw/rtl/aavg7s_sample_if.sv
hw/rtl/aavg7s_result_if.sv
hw/rtl/aavg7s_cfg_if.sv
hw/rtl/aavg7s_divider.sv
hw/rtl/aavg7s_bcd.sv
hw/rtl/adc_average_to_seven_segment_top.sv
test/tb.sv
